// ===== rtl/bigu_pkg.sv =====
// ============================================================================
// Broadcast index generator package
// Shared field widths, register indexes and the result and control structs.
// ============================================================================
package bigu_pkg;

    localparam int FIELD_W     = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int RANK_W      = 3;
    localparam int SLOT_W      = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANK_FIRST   = 2'd0,
        REG_RANK_SECOND  = 2'd1,
        REG_SHAPE_FIRST  = 2'd2,
        REG_SHAPE_SECOND = 2'd3
    } bigu_cfg_reg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_index;
        logic [FIELD_W-1:0] index_first;
        logic [FIELD_W-1:0] index_second;
        logic               last;
        logic               not_broadcastable;
    } bigu_result_t;

    typedef struct packed {
        logic accept;
        logic restart;
        logic home;
    } bigu_walk_ctrl_t;

    // A rank of zero counts as one, a rank above the maximum as the maximum.
    function automatic logic [RANK_W-1:0] clamp_rank(input logic [RANK_W-1:0] r,
                                                     input logic [RANK_W-1:0] max_rank);
        logic [RANK_W-1:0] res;
        res = r;
        if (r == '0)
        begin
            res = RANK_W'(1);
        end
        else if (r > max_rank)
        begin
            res = max_rank;
        end
        return res;
    endfunction

endpackage

// ===== rtl/bigu_walker.sv =====
// ============================================================================
// Broadcast index walker
// Holds the output coordinates and per-dimension base indices and produces
// the index pair of one element per accepted request.
// ============================================================================
module bigu_walker #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bigu_pkg::bigu_walk_ctrl_t ctrl,
    input  logic [EXTENT_BITS-1:0]  ext_first     [MAX_RANK],
    input  logic [EXTENT_BITS-1:0]  ext_second    [MAX_RANK],
    input  logic [INDEX_BITS-1:0]   stride_first  [MAX_RANK],
    input  logic [INDEX_BITS-1:0]   stride_second [MAX_RANK],
    output bigu_pkg::bigu_result_t  result
);
    import bigu_pkg::*;

    localparam logic [EXTENT_BITS-1:0] EXT_ONE = EXTENT_BITS'(1);

    // Base index of dimension k: the operand index with every dimension below k at zero.
    logic [EXTENT_BITS-1:0] coord_reg  [MAX_RANK];
    logic [EXTENT_BITS-1:0] coord_next [MAX_RANK];
    logic [INDEX_BITS-1:0]  base1_reg  [MAX_RANK];
    logic [INDEX_BITS-1:0]  base1_next [MAX_RANK];
    logic [INDEX_BITS-1:0]  base2_reg  [MAX_RANK];
    logic [INDEX_BITS-1:0]  base2_next [MAX_RANK];
    logic [INDEX_BITS-1:0]  count_reg;
    logic [INDEX_BITS-1:0]  count_next;

    logic [EXTENT_BITS-1:0] ext_res [MAX_RANK];
    logic [EXTENT_BITS-1:0] cur_c   [MAX_RANK];
    logic [INDEX_BITS-1:0]  cur_b1  [MAX_RANK];
    logic [INDEX_BITS-1:0]  cur_b2  [MAX_RANK];
    logic [INDEX_BITS-1:0]  step1   [MAX_RANK];
    logic [INDEX_BITS-1:0]  step2   [MAX_RANK];
    logic [MAX_RANK-1:0]    inc;
    logic [MAX_RANK-1:0]    sel;
    logic [MAX_RANK-1:0]    below;
    logic [INDEX_BITS-1:0]  cur_cnt;
    logic [INDEX_BITS-1:0]  add1_a;
    logic [INDEX_BITS-1:0]  add1_b;
    logic [INDEX_BITS-1:0]  add2_a;
    logic [INDEX_BITS-1:0]  add2_b;
    logic [INDEX_BITS-1:0]  adv1;
    logic [INDEX_BITS-1:0]  adv2;
    logic                   bad;
    logic                   empty;
    logic                   is_last;

    always_comb
    begin
        logic found;
        logic any_sel;
        bad   = 1'b0;
        empty = 1'b0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if ((ext_first[k] == ext_second[k]) || (ext_second[k] == EXT_ONE))
            begin
                ext_res[k] = ext_first[k];
            end
            else if (ext_first[k] == EXT_ONE)
            begin
                ext_res[k] = ext_second[k];
            end
            else
            begin
                ext_res[k] = EXT_ONE;
                bad        = 1'b1;
            end
            if (ext_res[k] == '0)
            begin
                empty = 1'b1;
            end
            step1[k]  = (ext_first[k] != EXT_ONE) ? stride_first[k] : '0;
            step2[k]  = (ext_second[k] != EXT_ONE) ? stride_second[k] : '0;
            cur_c[k]  = ctrl.restart ? '0 : coord_reg[k];
            cur_b1[k] = ctrl.restart ? '0 : base1_reg[k];
            cur_b2[k] = ctrl.restart ? '0 : base2_reg[k];
        end
        cur_cnt = ctrl.restart ? '0 : count_reg;

        // The innermost dimension that can still count up takes the carry.
        is_last = 1'b1;
        found   = 1'b0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            inc[k] = ({1'b0, cur_c[k]} + (EXTENT_BITS+1)'(1)) < {1'b0, ext_res[k]};
            if (({1'b0, cur_c[k]} + (EXTENT_BITS+1)'(1)) != {1'b0, ext_res[k]})
            begin
                is_last = 1'b0;
            end
            sel[k] = inc[k] && !found;
            found  = found || inc[k];
        end
        any_sel = 1'b0;
        for (int k = MAX_RANK - 1; k >= 0; k--)
        begin
            below[k] = any_sel;
            any_sel  = any_sel || sel[k];
        end

        add1_a = '0;
        add1_b = '0;
        add2_a = '0;
        add2_b = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if (sel[k])
            begin
                add1_a = add1_a | cur_b1[k];
                add1_b = add1_b | step1[k];
                add2_a = add2_a | cur_b2[k];
                add2_b = add2_b | step2[k];
            end
        end
        adv1 = add1_a + add1_b;
        adv2 = add2_a + add2_b;

        for (int k = 0; k < MAX_RANK; k++)
        begin
            if (bad || empty || is_last)
            begin
                coord_next[k] = '0;
                base1_next[k] = '0;
                base2_next[k] = '0;
            end
            else if (sel[k])
            begin
                coord_next[k] = cur_c[k] + EXT_ONE;
                base1_next[k] = adv1;
                base2_next[k] = adv2;
            end
            else if (below[k])
            begin
                coord_next[k] = '0;
                base1_next[k] = adv1;
                base2_next[k] = adv2;
            end
            else
            begin
                coord_next[k] = cur_c[k];
                base1_next[k] = cur_b1[k];
                base2_next[k] = cur_b2[k];
            end
        end
        count_next = (bad || empty || is_last) ? '0 : cur_cnt + INDEX_BITS'(1);

        if (bad || empty)
        begin
            result.out_index         = '0;
            result.index_first       = '0;
            result.index_second      = '0;
            result.last              = 1'b1;
            result.not_broadcastable = bad;
        end
        else
        begin
            result.out_index         = FIELD_W'(cur_cnt);
            result.index_first       = FIELD_W'(cur_b1[0]);
            result.index_second      = FIELD_W'(cur_b2[0]);
            result.last              = is_last;
            result.not_broadcastable = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_RANK; k++)
            begin
                coord_reg[k] <= '0;
                base1_reg[k] <= '0;
                base2_reg[k] <= '0;
            end
            count_reg <= '0;
        end
        else if (ctrl.home)
        begin
            for (int k = 0; k < MAX_RANK; k++)
            begin
                coord_reg[k] <= '0;
                base1_reg[k] <= '0;
                base2_reg[k] <= '0;
            end
            count_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            for (int k = 0; k < MAX_RANK; k++)
            begin
                coord_reg[k] <= coord_next[k];
                base1_reg[k] <= base1_next[k];
                base2_reg[k] <= base2_next[k];
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/bigu_skid.sv =====
// ============================================================================
// Broadcast index result buffer
// Output register with one skid entry, so a request is taken while a
// finished result still waits for the receiver.
// ============================================================================
module bigu_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  bigu_pkg::bigu_result_t load_data,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output bigu_pkg::bigu_result_t out_data
);
    import bigu_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    bigu_result_t main_reg;
    bigu_result_t skid_reg;
    logic         pop;
    logic         load_main;
    logic         load_skid;

    always_comb
    begin
        pop       = out_valid_reg && !out_stall;
        load_main = !skid_valid_reg && load && (!out_valid_reg || pop);
        load_skid = !skid_valid_reg && load && out_valid_reg && !pop;
        if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = !pop;
        end
        else
        begin
            out_valid_next  = load || (out_valid_reg && !pop);
            skid_valid_next = load_skid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && pop)
        begin
            main_reg <= skid_reg;
        end
        else if (load_main)
        begin
            main_reg <= load_data;
        end
        if (load_skid)
        begin
            skid_reg <= load_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== rtl/broadcast_index_generator_unit.sv =====
// ============================================================================
// Broadcast index generator
// Walks the broadcast of two operands in row-major order and gives, for each
// request, the output index and the source index into each operand.
// ============================================================================
// Usage: write rank_first, rank_second, shape_first and shape_second through
// the cfg_write/cfg_index/cfg_data port while the block is idle. Every write
// returns the sweep to element 0 and starts a stride pass (one product per
// cycle on each operand's own multiplier) during which in_stall is high.
// Input channel: in_valid/in_stall, payload restart. Each request yields
// exactly one result on out_valid/out_stall through the registered result buffer.
// Throughput is one request per cycle while in_stall is low; the per-dimension
// base registers advance with a single add per operand per element.
// When the receiver stalls, one more request is held in a skid entry; after
// that in_stall rises until the receiver drains the result register.
// Reset restores every register to 1 (scalar operands), clears the sweep,
// sets all strides to 1 and leaves the output channel empty.
// ============================================================================
module broadcast_index_generator_unit #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [bigu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bigu_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bigu_pkg::FIELD_W-1:0]     out_index,
    output logic [bigu_pkg::FIELD_W-1:0]     index_first,
    output logic [bigu_pkg::FIELD_W-1:0]     index_second,
    output logic                             last,
    output logic                             not_broadcastable
);
    import bigu_pkg::*;

    localparam int STEP_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam logic [RANK_W-1:0] MAX_RANK_R = RANK_W'(MAX_RANK);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(MAX_RANK - 1);

    logic [RANK_W-1:0]      rank_first_reg;
    logic [RANK_W-1:0]      rank_second_reg;
    logic [CFG_W-1:0]       shape_first_reg;
    logic [CFG_W-1:0]       shape_second_reg;

    logic [RANK_W-1:0]      r1;
    logic [RANK_W-1:0]      r2;
    logic [EXTENT_BITS-1:0] ext_first  [MAX_RANK];
    logic [EXTENT_BITS-1:0] ext_second [MAX_RANK];

    logic                   prep_busy_reg;
    logic [STEP_W-1:0]      prep_step_reg;
    logic [STEP_W-1:0]      step_prev;
    logic [INDEX_BITS-1:0]  stride_first_reg  [MAX_RANK];
    logic [INDEX_BITS-1:0]  stride_second_reg [MAX_RANK];
    logic [INDEX_BITS+EXTENT_BITS-1:0] prod_first;
    logic [INDEX_BITS+EXTENT_BITS-1:0] prod_second;

    logic                   accept;
    logic                   skid_full;
    bigu_walk_ctrl_t        walk_ctrl;
    bigu_result_t           walk_result;
    bigu_result_t           out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_first_reg   <= RANK_W'(1);
            rank_second_reg  <= RANK_W'(1);
            shape_first_reg  <= CFG_W'(1);
            shape_second_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (bigu_cfg_reg_t'(cfg_index))
                REG_RANK_FIRST:   rank_first_reg   <= cfg_data[RANK_W-1:0];
                REG_RANK_SECOND:  rank_second_reg  <= cfg_data[RANK_W-1:0];
                REG_SHAPE_FIRST:  shape_first_reg  <= cfg_data;
                REG_SHAPE_SECOND: shape_second_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Slots at or beyond an operand's clamped rank read as extent 1.
    always_comb
    begin
        r1 = clamp_rank(rank_first_reg, MAX_RANK_R);
        r2 = clamp_rank(rank_second_reg, MAX_RANK_R);
        for (int k = 0; k < MAX_RANK; k++)
        begin
            ext_first[k]  = (RANK_W'(k) < r1) ? shape_first_reg[SLOT_W*k +: EXTENT_BITS]
                                              : EXTENT_BITS'(1);
            ext_second[k] = (RANK_W'(k) < r2) ? shape_second_reg[SLOT_W*k +: EXTENT_BITS]
                                              : EXTENT_BITS'(1);
        end
    end

    // Stride k is the product of the extents below k, built one dimension a cycle.
    assign step_prev   = prep_step_reg - STEP_W'(1);
    assign prod_first  = stride_first_reg[step_prev] * ext_first[step_prev];
    assign prod_second = stride_second_reg[step_prev] * ext_second[step_prev];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_busy_reg <= 1'b0;
            prep_step_reg <= STEP_W'(1);
            for (int k = 0; k < MAX_RANK; k++)
            begin
                stride_first_reg[k]  <= INDEX_BITS'(1);
                stride_second_reg[k] <= INDEX_BITS'(1);
            end
        end
        else if (cfg_write && (MAX_RANK > 1))
        begin
            prep_busy_reg <= 1'b1;
            prep_step_reg <= STEP_W'(1);
        end
        else if (prep_busy_reg)
        begin
            stride_first_reg[prep_step_reg]  <= prod_first[INDEX_BITS-1:0];
            stride_second_reg[prep_step_reg] <= prod_second[INDEX_BITS-1:0];
            if (prep_step_reg == STEP_LAST)
            begin
                prep_busy_reg <= 1'b0;
            end
            else
            begin
                prep_step_reg <= prep_step_reg + STEP_W'(1);
            end
        end
    end

    assign in_stall          = skid_full || prep_busy_reg;
    assign accept            = in_valid && !in_stall;
    assign walk_ctrl.accept  = accept;
    assign walk_ctrl.restart = restart;
    assign walk_ctrl.home    = cfg_write;

    bigu_walker #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (walk_ctrl),
        .ext_first     (ext_first),
        .ext_second    (ext_second),
        .stride_first  (stride_first_reg),
        .stride_second (stride_second_reg),
        .result        (walk_result)
    );

    bigu_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (walk_result),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_index         = out_data.out_index;
    assign index_first       = out_data.index_first;
    assign index_second      = out_data.index_second;
    assign last              = out_data.last;
    assign not_broadcastable = out_data.not_broadcastable;

endmodule

// ===== sim/broadcast_index_generator_unit_test.sv =====
// ============================================================================
// Broadcast index generator testbench
// Drives sweep requests through the broadcast index generator under several
// shape settings and idle patterns, predicts every element's output index and
// source indices in a local walk of the broadcast, and checks each result.
// ============================================================================
module broadcast_index_generator_unit_test;

    import bigu_pkg::*;

    localparam int MAX_RANK        = 4;
    localparam int EXTENT_BITS     = 16;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 150;
    localparam logic [63:0] INDEX_MASK = 64'hFFFF_FFFF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   restart;
    logic                   out_valid;
    logic                   out_stall;
    logic [FIELD_W-1:0]     out_index;
    logic [FIELD_W-1:0]     index_first;
    logic [FIELD_W-1:0]     index_second;
    logic                   last;
    logic                   not_broadcastable;

    // Local copy of the configuration and of the sweep position.
    logic [2:0]  model_rank_a;
    logic [2:0]  model_rank_b;
    logic [63:0] model_shape_a;
    logic [63:0] model_shape_b;
    logic [63:0] walk_coord [0:MAX_RANK-1];
    logic [31:0] walk_count;

    logic         pending_restarts [$];
    bigu_result_t expected_elements [$];

    idle_mode_t idle_mode;
    logic       in_taken;
    int         requests_queued;
    int         requests_taken;
    int         results_checked;
    int         mismatch_count;
    int         settings_loaded;
    int         quiet_cycles;
    int         rx_hold_seq;
    int         rx_hold_seen;
    int         rx_hold_left;

    broadcast_index_generator_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .restart           (restart),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_index         (out_index),
        .index_first       (index_first),
        .index_second      (index_second),
        .last              (last),
        .not_broadcastable (not_broadcastable)
    );

    always #5 clk = ~clk;

    function automatic int effective_rank(input logic [2:0] r);
        if (r == 3'd0)
        begin
            return 1;
        end
        if (int'(r) > MAX_RANK)
        begin
            return MAX_RANK;
        end
        return int'(r);
    endfunction

    function automatic void home_walk();
        for (int k = 0; k < MAX_RANK; k++)
        begin
            walk_coord[k] = 64'd0;
        end
        walk_count = 32'd0;
    endfunction

    // Produces the element for one request and advances the sweep.
    function automatic bigu_result_t next_element(input logic restart_req);
        logic [63:0] ext_a [0:MAX_RANK-1];
        logic [63:0] ext_b [0:MAX_RANK-1];
        logic [63:0] ext_r [0:MAX_RANK-1];
        logic [63:0] pos;
        logic [63:0] idx_a;
        logic [63:0] idx_b;
        logic [63:0] stride_a;
        logic [63:0] stride_b;
        int          rank_a;
        int          rank_b;
        logic        bad;
        logic        empty;
        logic        at_end;
        bigu_result_t res;
        rank_a   = effective_rank(model_rank_a);
        rank_b   = effective_rank(model_rank_b);
        bad      = 1'b0;
        empty    = 1'b0;
        at_end   = 1'b1;
        idx_a    = 64'd0;
        idx_b    = 64'd0;
        stride_a = 64'd1;
        stride_b = 64'd1;
        res      = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            ext_a[k] = (k < rank_a) ? 64'(model_shape_a[EXTENT_BITS*k +: EXTENT_BITS]) : 64'd1;
            ext_b[k] = (k < rank_b) ? 64'(model_shape_b[EXTENT_BITS*k +: EXTENT_BITS]) : 64'd1;
            if (ext_a[k] == ext_b[k] || ext_b[k] == 64'd1)
            begin
                ext_r[k] = ext_a[k];
            end
            else if (ext_a[k] == 64'd1)
            begin
                ext_r[k] = ext_b[k];
            end
            else
            begin
                ext_r[k] = 64'd1;
                bad      = 1'b1;
            end
            if (ext_r[k] == 64'd0)
            begin
                empty = 1'b1;
            end
        end
        if (bad || empty)
        begin
            // Nothing to walk: every request reports a finished, empty sweep.
            home_walk();
            res.last              = 1'b1;
            res.not_broadcastable = bad;
            return res;
        end
        if (restart_req)
        begin
            home_walk();
        end
        for (int k = 0; k < MAX_RANK; k++)
        begin
            pos = walk_coord[k];
            if (pos >= ext_r[k])
            begin
                pos = ext_r[k] - 64'd1;
            end
            walk_coord[k] = pos;
            idx_a    = (idx_a + ((ext_a[k] == 64'd1) ? 64'd0 : pos) * stride_a) & INDEX_MASK;
            idx_b    = (idx_b + ((ext_b[k] == 64'd1) ? 64'd0 : pos) * stride_b) & INDEX_MASK;
            stride_a = (stride_a * ext_a[k]) & INDEX_MASK;
            stride_b = (stride_b * ext_b[k]) & INDEX_MASK;
            if (pos != ext_r[k] - 64'd1)
            begin
                at_end = 1'b0;
            end
        end
        res.out_index    = walk_count;
        res.index_first  = idx_a[31:0];
        res.index_second = idx_b[31:0];
        res.last         = at_end;
        if (at_end)
        begin
            home_walk();
        end
        else
        begin
            for (int k = 0; k < MAX_RANK; k++)
            begin
                if (walk_coord[k] + 64'd1 < ext_r[k])
                begin
                    walk_coord[k] = walk_coord[k] + 64'd1;
                    break;
                end
                walk_coord[k] = 64'd0;
            end
            walk_count = walk_count + 32'd1;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 82;
            IDLE_BOTH:   return $urandom_range(0, 99) < 10;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_rests();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 82;
            IDLE_BOTH:     return $urandom_range(0, 99) < 10;
            default:       return 1'b0;
        endcase
    endfunction

    // Request driver: a request stays up until it is taken.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_restarts.size() != 0 && !sender_rests())
            begin
                restart  <= pending_restarts.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (rx_hold_seen != rx_hold_seq)
        begin
            rx_hold_seen <= rx_hold_seq;
            rx_hold_left <= HOLD_OFF_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_stall    <= 1'b1;
        end
        else
        begin
            out_stall <= receiver_rests();
        end
    end

    // Monitor: predicts on each taken request, checks each delivered result.
    always @(posedge clk)
    begin
        bigu_result_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_elements.push_back(next_element(restart));
                requests_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_elements.size() == 0)
                begin
                    $error("result delivered with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_elements.pop_front();
                    check_field("out_index", want.out_index, out_index);
                    check_field("index_first", want.index_first, index_first);
                    check_field("index_second", want.index_second, index_second);
                    check_field("last", 32'(want.last), 32'(last));
                    check_field("not_broadcastable", 32'(want.not_broadcastable),
                                32'(not_broadcastable));
                    results_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic queue_req(input logic rs);
        pending_restarts.push_back(rs);
        requests_queued++;
    endtask

    task automatic queue_batch(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
        begin
            queue_req($urandom_range(0, 99) < restart_pct);
        end
    endtask

    task automatic wait_drained();
        while (requests_taken != requests_queued || expected_elements.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input bigu_cfg_reg_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_RANK_FIRST:   model_rank_a  = val[2:0];
            REG_RANK_SECOND:  model_rank_b  = val[2:0];
            REG_SHAPE_FIRST:  model_shape_a = val;
            REG_SHAPE_SECOND: model_shape_b = val;
            default:          ;
        endcase
        home_walk();
    endtask

    task automatic load_shapes(input logic [2:0] ra, input logic [2:0] rb,
                               input logic [63:0] sa, input logic [63:0] sb);
        write_reg(REG_RANK_FIRST, 64'(ra));
        write_reg(REG_RANK_SECOND, 64'(rb));
        write_reg(REG_SHAPE_FIRST, sa);
        write_reg(REG_SHAPE_SECOND, sb);
        settings_loaded++;
    endtask

    // Mostly broadcast-compatible small shapes with random bits in unused slots;
    // the wide flavor gives the first operand random nonzero extents on all four dimensions.
    task automatic pick_shapes(input bit wide, output logic [2:0] ra, output logic [2:0] rb,
                               output logic [63:0] sa, output logic [63:0] sb);
        int          res_ext;
        int          eff_a;
        int          eff_b;
        int          flavor;
        logic [15:0] ext;
        sa = {$urandom, $urandom};
        sb = {$urandom, $urandom};
        if (wide)
        begin
            ra = 3'd4;
            rb = 3'($urandom_range(1, 4));
            for (int k = 0; k < MAX_RANK; k++)
            begin
                ext = sa[EXTENT_BITS*k +: EXTENT_BITS];
                if (ext == 16'd0)
                begin
                    ext = 16'hFFFF;
                end
                sa[EXTENT_BITS*k +: EXTENT_BITS] = ext;
                sb[EXTENT_BITS*k +: EXTENT_BITS] = $urandom_range(0, 1) ? ext : 16'd1;
            end
        end
        else
        begin
            ra = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            rb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            eff_a = effective_rank(ra);
            eff_b = effective_rank(rb);
            for (int k = 0; k < MAX_RANK; k++)
            begin
                res_ext = $urandom_range(1, 4);
                if (k < eff_a)
                begin
                    sa[EXTENT_BITS*k +: EXTENT_BITS] =
                        ($urandom_range(0, 2) == 0) ? 16'd1 : 16'(res_ext);
                end
                if (k < eff_b)
                begin
                    sb[EXTENT_BITS*k +: EXTENT_BITS] =
                        ($urandom_range(0, 2) == 0) ? 16'd1 : 16'(res_ext);
                end
            end
            flavor = $urandom_range(0, 9);
            if (flavor == 8)
            begin
                sa[15:0] = 16'd3;
                sb[15:0] = 16'd2;
            end
            else if (flavor == 9)
            begin
                sa[15:0] = 16'd0;
                sb[15:0] = 16'd1;
            end
        end
    endtask

    initial
    begin
        logic [2:0]    ra;
        logic [2:0]    rb;
        logic [63:0]   sa;
        logic [63:0]   sb;
        logic [63:0]   again;
        bigu_cfg_reg_t pick;
        int            half;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_RANK_FIRST;
        cfg_data        = '0;
        in_valid        = 1'b0;
        restart         = 1'b0;
        out_stall       = 1'b0;
        in_taken        = 1'b0;
        idle_mode       = IDLE_NONE;
        requests_queued = 0;
        requests_taken  = 0;
        results_checked = 0;
        mismatch_count  = 0;
        settings_loaded = 0;
        quiet_cycles    = 0;
        rx_hold_seq     = 0;
        rx_hold_seen    = 0;
        rx_hold_left    = 0;
        model_rank_a    = 3'd1;
        model_rank_b    = 3'd1;
        model_shape_a   = 64'd1;
        model_shape_b   = 64'd1;
        home_walk();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Scalar operands out of reset; the first advance still gives element 0.
        queue_req(1'b0);
        queue_req(1'b1);
        queue_req(1'b0);
        queue_req(1'b0);
        wait_drained();

        // Largest extents on every dimension of both operands.
        load_shapes(3'd4, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(1'b1);
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b1);
        wait_drained();

        // Extents 2x3 against 2x4 cannot be broadcast.
        load_shapes(3'd2, 3'd2, 64'h0000_0000_0003_0002, 64'h0000_0000_0004_0002);
        queue_req(1'b0);
        queue_req(1'b1);
        queue_req(1'b0);
        wait_drained();

        // A zero extent leaves the output empty.
        load_shapes(3'd1, 3'd1, 64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0000_0001);
        queue_req(1'b0);
        queue_req(1'b1);
        wait_drained();

        // Rank zero counts as one and rank seven as four; unused slots are ignored.
        load_shapes(3'd0, 3'd7, 64'hABCD_1234_5678_0003, 64'h0001_0002_0001_0001);
        for (int i = 0; i < 7; i++)
        begin
            queue_req(1'b0);
        end
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            pick_shapes(phase == RANDOM_PHASES - 1, ra, rb, sa, sb);
            load_shapes(ra, rb, sa, sb);
            if (phase == 0)
            begin
                // Receiver holds off while requests keep coming, so the block fills up.
                rx_hold_seq++;
            end
            half = PHASE_REQUESTS / 2;
            queue_batch(half, $urandom_range(2, 8));
            wait_drained();
            if (phase % 2 == 1)
            begin
                // Rewriting any register with its own value must still home the sweep.
                pick = bigu_cfg_reg_t'($urandom_range(0, 3));
                case (pick)
                    REG_RANK_FIRST:  again = 64'(model_rank_a);
                    REG_RANK_SECOND: again = 64'(model_rank_b);
                    REG_SHAPE_FIRST: again = model_shape_a;
                    default:         again = model_shape_b;
                endcase
                write_reg(pick, again);
            end
            queue_batch(PHASE_REQUESTS - half, $urandom_range(2, 8));
            wait_drained();
        end

        $display("Ran %0d requests over %0d shape settings, including empty, incompatible,",
                 requests_taken, settings_loaded);
        $display("clamped-rank and full-extent shapes; %0d results checked, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_elements.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bigu_pkg.sv
rtl/bigu_walker.sv
rtl/bigu_skid.sv
rtl/broadcast_index_generator_unit.sv
sim/broadcast_index_generator_unit_test.sv
